// File: src/pmc_pkg.sv
// Shared types, codes and reset values for the power-mode controller.
package pmc_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned REG_W     = 24;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned S_DATA_W  = 40;
    localparam int unsigned S_USER_W  = 2;
    localparam int unsigned M_DATA_W  = 8;

    // Power modes
    localparam logic [1:0] MODE_WAIT   = 2'd0;
    localparam logic [1:0] MODE_ACTIVE = 2'd1;
    localparam logic [1:0] MODE_LOW    = 2'd2;
    localparam logic [1:0] MODE_OFF    = 2'd3;

    // Operations
    localparam logic [1:0] FUNC_UPDATE    = 2'd0;
    localparam logic [1:0] FUNC_BUTTON    = 2'd1;
    localparam logic [1:0] FUNC_LOW_POWER = 2'd2;
    localparam logic [1:0] FUNC_WAKE      = 2'd3;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HOLD      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MOTION_SCREEN    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CONNECTED_MOTION = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RADIO_WAIT       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOW_POWER_OFF    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVITY_GUARD   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RECENT_ACTIVITY  = 3'd6;

    // Reset values
    localparam logic [REG_W-1:0] RST_SCREEN_HOLD      = 24'd60000;
    localparam logic [REG_W-1:0] RST_MOTION_SCREEN    = 24'd30000;
    localparam logic [REG_W-1:0] RST_CONNECTED_MOTION = 24'd300000;
    localparam logic [REG_W-1:0] RST_RADIO_WAIT       = 24'd300000;
    localparam logic [REG_W-1:0] RST_LOW_POWER_OFF    = 24'd120000;
    localparam logic [REG_W-1:0] RST_ACTIVITY_GUARD   = 24'd60000;
    localparam logic [REG_W-1:0] RST_RECENT_ACTIVITY  = 24'd30000;

    typedef struct packed {
        logic [REG_W-1:0] screen_hold_ms;
        logic [REG_W-1:0] motion_screen_ms;
        logic [REG_W-1:0] connected_motion_ms;
        logic [REG_W-1:0] radio_wait_ms;
        logic [REG_W-1:0] low_power_off_ms;
        logic [REG_W-1:0] activity_guard_ms;
        logic [REG_W-1:0] recent_activity_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [TIME_W-1:0] time_ms;
        logic              motion_detected;
        logic              device_connected;
        logic              peer_app_connected;
        logic              calibrating;
    } item_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic              screen;
        logic [TIME_W-1:0] last_motion_time;
        logic [TIME_W-1:0] last_button_time;
        logic [TIME_W-1:0] radio_start_time;
    } state_t;

    typedef struct packed {
        logic [1:0] power_mode;
        logic       screen_on;
        logic       power_off_request;
        logic       radio_enable;
        logic       request_refused;
    } result_t;

endpackage

// File: src/power_mode_controller_core.sv
// Top level of the power-mode controller: input stage, state, decision logic, result register.
//
//  Channel   Direction  Ports                               Beat contents
//  s_        in         s_tvalid s_tready s_tdata s_tuser   one event with its timestamp
//  m_        out        m_tvalid m_tready m_tdata           mode and flags after the event
//  cfg_      in         cfg_wr_en cfg_index cfg_wdata       one timeout register write
//
// One beat is accepted per cycle unless the master side stalls; a result is offered from
// the result register once its beat has passed the input register. State is updated in the
// same cycle as the result register, so the next input beat always sees the state left by the last.
// Reset is synchronous and restores the register defaults and radio waiting mode, screen on.
// A stall on the master side holds the result; the input register can still take one more beat if empty.
module power_mode_controller_core
    import pmc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, lowest bit up: time_ms[31:0], motion_detected, device_connected,
    // peer_app_connected, calibrating, zero padding [39:36]
    input  logic [S_DATA_W-1:0]  s_tdata,
    // s_tuser: func[1:0]
    input  logic [S_USER_W-1:0]  s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, lowest bit up: power_mode[1:0], screen_on, power_off_request,
    // radio_enable, request_refused, zero padding [7:6]
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata
);

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    logic    take;
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    pmc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pmc_input_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    pmc_step u_step (
        .item (item),
        .cur  (state_reg),
        .cfg  (cfg),
        .nxt  (state_next),
        .res  (step_res)
    );

    assign take           = item_valid && (!out_valid_reg || m_tready);
    assign out_valid_next = take || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode             <= MODE_WAIT;
            state_reg.screen           <= 1'b1;
            state_reg.last_motion_time <= '0;
            state_reg.last_button_time <= '0;
            state_reg.radio_start_time <= '0;
            out_valid_reg              <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       result_reg.request_refused,
                       result_reg.radio_enable,
                       result_reg.power_off_request,
                       result_reg.screen_on,
                       result_reg.power_mode};

`ifndef SYNTHESIS
    // An off request is only ever raised together with off mode.
    a_pulse_means_off: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.power_off_request |-> result_reg.power_mode == MODE_OFF)
        else $error("power off request without off mode");

    // A refused request leaves no off request behind.
    a_refused_no_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.request_refused |-> !result_reg.power_off_request)
        else $error("refused request together with off request");

    // The mode shown on the output is the mode the controller holds.
    a_result_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> result_reg.power_mode == state_reg.mode &&
                          result_reg.screen_on == state_reg.screen)
        else $error("result out of step with controller state");

    // The state only moves when a beat is processed.
    a_state_moves_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        !take |=> $stable(state_reg))
        else $error("controller state changed without a beat");
`endif

endmodule

// File: src/pmc_cfg_regs.sv
// Configuration register file of the power-mode controller.
module pmc_cfg_regs
    import pmc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCREEN_HOLD:      cfg_next.screen_hold_ms      = cfg_wdata;
                REG_MOTION_SCREEN:    cfg_next.motion_screen_ms    = cfg_wdata;
                REG_CONNECTED_MOTION: cfg_next.connected_motion_ms = cfg_wdata;
                REG_RADIO_WAIT:       cfg_next.radio_wait_ms       = cfg_wdata;
                REG_LOW_POWER_OFF:    cfg_next.low_power_off_ms    = cfg_wdata;
                REG_ACTIVITY_GUARD:   cfg_next.activity_guard_ms   = cfg_wdata;
                REG_RECENT_ACTIVITY:  cfg_next.recent_activity_ms  = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_hold_ms      <= RST_SCREEN_HOLD;
            cfg_reg.motion_screen_ms    <= RST_MOTION_SCREEN;
            cfg_reg.connected_motion_ms <= RST_CONNECTED_MOTION;
            cfg_reg.radio_wait_ms       <= RST_RADIO_WAIT;
            cfg_reg.low_power_off_ms    <= RST_LOW_POWER_OFF;
            cfg_reg.activity_guard_ms   <= RST_ACTIVITY_GUARD;
            cfg_reg.recent_activity_ms  <= RST_RECENT_ACTIVITY;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/pmc_input_reg.sv
// Input register stage: captures one beat from the slave side.
module pmc_input_reg
    import pmc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [S_USER_W-1:0] s_tuser,
    input  logic                take,
    output logic                item_valid,
    output item_t               item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.func               <= s_tuser[1:0];
            item_reg.time_ms            <= s_tdata[TIME_W-1:0];
            item_reg.motion_detected    <= s_tdata[TIME_W];
            item_reg.device_connected   <= s_tdata[TIME_W+1];
            item_reg.peer_app_connected <= s_tdata[TIME_W+2];
            item_reg.calibrating        <= s_tdata[TIME_W+3];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: src/pmc_step.sv
// Decision logic: next controller state and result for one item.
module pmc_step
    import pmc_pkg::*;
(
    input  item_t   item,
    input  state_t  cur,
    input  cfg_t    cfg,
    output state_t  nxt,
    output result_t res
);

    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] motion_time;
    logic [TIME_W-1:0] dm;
    logic [TIME_W-1:0] db;
    logic [TIME_W-1:0] idle;
    logic [TIME_W-1:0] since_start;
    logic              keep;
    logic              pulse;
    logic              refused;

    always_comb begin
        now         = item.time_ms;
        // Motion is recorded before any timing decision of the same update.
        motion_time = (item.func == FUNC_UPDATE && item.motion_detected) ?
                      now : cur.last_motion_time;
        dm          = now - motion_time;
        db          = now - cur.last_button_time;
        idle        = (dm < db) ? dm : db;
        since_start = now - cur.radio_start_time;

        if (db <= {8'd0, cfg.screen_hold_ms}) begin
            keep = 1'b1;
        end else if (item.peer_app_connected) begin
            keep = 1'b1;
        end else if (item.device_connected) begin
            keep = dm <= {8'd0, cfg.connected_motion_ms};
        end else begin
            keep = dm <= {8'd0, cfg.motion_screen_ms};
        end

        nxt                  = cur;
        nxt.last_motion_time = motion_time;
        pulse                = 1'b0;
        refused              = 1'b0;

        unique case (item.func)
            FUNC_UPDATE: begin
                nxt.screen = keep;
                if (item.device_connected) begin
                    nxt.mode = MODE_ACTIVE;
                end else if (!item.calibrating) begin
                    unique case (cur.mode)
                        MODE_WAIT: begin
                            if (since_start > {8'd0, cfg.radio_wait_ms} &&
                                idle > {8'd0, cfg.activity_guard_ms}) begin
                                nxt.mode   = MODE_OFF;
                                nxt.screen = 1'b0;
                                pulse      = 1'b1;
                            end else if (idle < {8'd0, cfg.recent_activity_ms}) begin
                                nxt.radio_start_time = now;
                            end
                        end
                        MODE_ACTIVE: begin
                            nxt.mode             = MODE_WAIT;
                            nxt.screen           = 1'b0;
                            nxt.radio_start_time = now;
                        end
                        MODE_LOW: begin
                            if (idle > {8'd0, cfg.low_power_off_ms}) begin
                                nxt.mode   = MODE_OFF;
                                nxt.screen = 1'b0;
                                pulse      = 1'b1;
                            end
                        end
                        MODE_OFF: begin
                            nxt.mode = MODE_OFF;
                        end
                        default: begin
                            nxt.mode = cur.mode;
                        end
                    endcase
                end
            end
            FUNC_BUTTON: begin
                nxt.last_button_time = now;
            end
            FUNC_LOW_POWER: begin
                if (cur.mode != MODE_LOW) begin
                    if (idle < {8'd0, cfg.activity_guard_ms}) begin
                        refused = 1'b1;
                    end else begin
                        nxt.mode   = MODE_LOW;
                        nxt.screen = 1'b0;
                    end
                end
            end
            FUNC_WAKE: begin
                if (cur.mode != MODE_WAIT) begin
                    nxt.mode             = MODE_WAIT;
                    nxt.screen           = 1'b0;
                    nxt.radio_start_time = now;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase

        res.power_mode        = nxt.mode;
        res.screen_on         = nxt.screen;
        res.power_off_request = pulse;
        res.radio_enable      = (nxt.mode == MODE_WAIT) || (nxt.mode == MODE_ACTIVE);
        res.request_refused   = refused;
    end

endmodule
